FILE: rtl/tmqtf_pkg.sv
package tmqtf_pkg;

   localparam int QUEUES_DEF = 4;
   localparam int DEPTH_DEF  = 3;

   localparam int SEL_W    = 2;
   localparam int ACTION_W = 2;
   localparam int TICKET_W = 16;
   localparam int DISH_W   = 8;

   localparam logic [TICKET_W-1:0] TICKET_START = TICKET_W'(1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQ     = 2'd0,
      ACT_DEQ     = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   typedef struct packed {
      logic [TICKET_W-1:0] ticket;
      logic [DISH_W-1:0]   dish;
   } slot_type;

endpackage

FILE: rtl/tmqtf_slot_ram.sv
module tmqtf_slot_ram #(
   parameter int ENTRIES = tmqtf_pkg::QUEUES_DEF * (tmqtf_pkg::DEPTH_DEF + 1),
   parameter int AW      = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tmqtf_pkg::slot_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output tmqtf_pkg::slot_type rd_data
);

   tmqtf_pkg::slot_type slot_mem_ff [ENTRIES];
   tmqtf_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tagged_multi_queue_ticket_fifo.sv
// Ticket FIFO with QUEUES circular queues of DEPTH usable slots each and one
// shared 16-bit ticket counter (starts at 1, wraps). Every request beat gives
// exactly one response beat. The head slot of the selected queue is read from
// the slot memory in the accept cycle; the evaluation state then evaluates,
// updates pointers and counter, writes the slot memory and loads the response
// register, waiting while an unread response is still held. That register
// frees the response side, so a new request is taken as soon as the evaluation
// has left its result, and not while an earlier one is still being evaluated.
// Out-of-range queue selects and unused action codes return all zero.
module tagged_multi_queue_ticket_fifo #(
   parameter int QUEUES = tmqtf_pkg::QUEUES_DEF,
   parameter int DEPTH  = tmqtf_pkg::DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tmqtf_pkg::ACTION_W-1:0]   req_action,
   input  logic [tmqtf_pkg::SEL_W-1:0]      req_queue_sel,
   input  logic [tmqtf_pkg::TICKET_W-1:0]   req_expected_ticket,
   input  logic [tmqtf_pkg::DISH_W-1:0]     req_dish_code,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [tmqtf_pkg::TICKET_W-1:0]   rsp_ticket_number,
   output logic [tmqtf_pkg::DISH_W-1:0]     rsp_dish_out
);

   localparam int SLOTS   = DEPTH + 1;
   localparam int PW      = $clog2(SLOTS);
   localparam int QIW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int ENTRIES = QUEUES * SLOTS;
   localparam int AW      = $clog2(ENTRIES);
   localparam int XW      = tmqtf_pkg::SEL_W + QIW;
   localparam int TW      = tmqtf_pkg::TICKET_W;
   localparam int DW      = tmqtf_pkg::DISH_W;

   tmqtf_pkg::state_type  state_ff, state_in;
   tmqtf_pkg::action_type item_action_ff;
   logic [QIW-1:0]        item_idx_ff;
   logic                  item_qok_ff;
   logic [TW-1:0]         item_expected_ff;
   logic [DW-1:0]         item_dish_ff;

   logic [PW-1:0] head_ff [QUEUES];
   logic [PW-1:0] tail_ff [QUEUES];
   logic [TW-1:0] next_ticket_ff, next_ticket_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_accepted_ff;
   logic [TW-1:0] rsp_ticket_ff;
   logic [DW-1:0] rsp_dish_ff;

   logic [XW-1:0]  sel_wide;
   logic [QIW-1:0] req_idx;
   logic           req_qok;
   logic           req_fire;

   logic [PW-1:0] cur_head, cur_tail, head_adv, tail_adv;
   logic          fire, res_acc, upd_head, upd_tail;
   logic [TW-1:0] res_ticket;
   logic [DW-1:0] res_dish;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   tmqtf_pkg::slot_type wr_data, rd_data;

   assign sel_wide = XW'(req_queue_sel);
   assign req_idx  = sel_wide[QIW-1:0];
   assign req_qok  = sel_wide < XW'(QUEUES);

   assign req_ready = (state_ff == tmqtf_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign rd_en   = req_fire && req_qok;
   assign rd_addr = AW'(req_idx) * AW'(SLOTS) + AW'(req_qok ? head_ff[req_idx] : '0);

   assign cur_head = item_qok_ff ? head_ff[item_idx_ff] : '0;
   assign cur_tail = item_qok_ff ? tail_ff[item_idx_ff] : '0;
   assign head_adv = (cur_head == PW'(DEPTH)) ? '0 : cur_head + PW'(1);
   assign tail_adv = (cur_tail == PW'(DEPTH)) ? '0 : cur_tail + PW'(1);

   assign fire = (state_ff == tmqtf_pkg::ST_EVAL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      res_acc        = 1'b0;
      res_ticket     = '0;
      res_dish       = '0;
      upd_head       = 1'b0;
      upd_tail       = 1'b0;
      next_ticket_in = next_ticket_ff;
      unique case (item_action_ff)
         tmqtf_pkg::ACT_ENQ: begin
            if (item_qok_ff && (tail_adv != cur_head)) begin
               res_acc        = 1'b1;
               res_ticket     = next_ticket_ff;
               upd_tail       = 1'b1;
               next_ticket_in = next_ticket_ff + TW'(1);
            end
         end
         tmqtf_pkg::ACT_DEQ: begin
            if (item_qok_ff && (cur_head != cur_tail)
                && (rd_data.ticket == item_expected_ff)) begin
               res_acc    = 1'b1;
               res_ticket = rd_data.ticket;
               res_dish   = rd_data.dish;
               upd_head   = 1'b1;
            end
         end
         tmqtf_pkg::ACT_RESTART: begin
            next_ticket_in = tmqtf_pkg::TICKET_START;
         end
         default: begin
         end
      endcase
   end

   assign wr_en          = fire && upd_tail;
   assign wr_addr        = AW'(item_idx_ff) * AW'(SLOTS) + AW'(cur_tail);
   assign wr_data.ticket = next_ticket_ff;
   assign wr_data.dish   = item_dish_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmqtf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tmqtf_pkg::ST_EVAL;
            end
         end
         tmqtf_pkg::ST_EVAL: begin
            if (fire) begin
               state_in = tmqtf_pkg::ST_IDLE;
            end
         end
         default: state_in = tmqtf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tmqtf_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         next_ticket_ff <= tmqtf_pkg::TICKET_START;
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            next_ticket_ff <= next_ticket_in;
            if (upd_head) begin
               head_ff[item_idx_ff] <= head_adv;
            end
            if (upd_tail) begin
               tail_ff[item_idx_ff] <= tail_adv;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_action_ff   <= tmqtf_pkg::action_type'(req_action);
         item_idx_ff      <= req_idx;
         item_qok_ff      <= req_qok;
         item_expected_ff <= req_expected_ticket;
         item_dish_ff     <= req_dish_code;
      end
      if (fire) begin
         rsp_accepted_ff <= res_acc;
         rsp_ticket_ff   <= res_ticket;
         rsp_dish_ff     <= res_dish;
      end
   end

   tmqtf_slot_ram #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_ticket_number = rsp_ticket_ff;
   assign rsp_dish_out      = rsp_dish_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == tmqtf_pkg::ST_EVAL))
      else $error("accepted beat did not enter evaluation");

   a_ticket_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(next_ticket_ff))
      else $error("ticket counter moved without an evaluation");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("slot memory written and read in the same cycle");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmqtf_pkg::ST_EVAL) |->
         (cur_head <= PW'(DEPTH)) && (cur_tail <= PW'(DEPTH)))
      else $error("queue pointer beyond last slot");
`endif

endmodule

FILE: test/ticket_fifo_checker.sv
module ticket_fifo_checker
   import tmqtf_pkg::*;
#(
   parameter int QUEUES = QUEUES_DEF,
   parameter int DEPTH  = DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [ACTION_W-1:0]             req_action,
   input  logic [SEL_W-1:0]                req_queue_sel,
   input  logic [TICKET_W-1:0]             req_expected_ticket,
   input  logic [DISH_W-1:0]               req_dish_code,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_accepted,
   input  logic [TICKET_W-1:0]             rsp_ticket_number,
   input  logic [DISH_W-1:0]               rsp_dish_out,
   output int                              failures,
   output int                              outstanding,
   output logic                            model_tick,
   output logic [QUEUES-1:0][TICKET_W-1:0] head_tickets,
   output logic [QUEUES-1:0][7:0]          fill_levels,
   output int                              issued_count,
   output int                              collected_count,
   output int                              refused_count,
   output int                              wrap_count
);

   localparam int SLOTS = DEPTH + 1;

   typedef struct packed {
      logic                accepted;
      logic [TICKET_W-1:0] ticket;
      logic [DISH_W-1:0]   dish;
   } reply_type;

   slot_type            ticket_slots [QUEUES][SLOTS];
   int                  head_idx [QUEUES];
   int                  tail_idx [QUEUES];
   logic [TICKET_W-1:0] ticket_counter;
   reply_type           owed_replies [$];

   initial begin
      failures        = 0;
      outstanding     = 0;
      model_tick      = 1'b0;
      issued_count    = 0;
      collected_count = 0;
      refused_count   = 0;
      wrap_count      = 0;
      head_tickets    = '0;
      fill_levels     = '0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
      failures++;
   endtask

   task automatic serve_ticket_desk(input logic [ACTION_W-1:0] act,
                                    input logic [SEL_W-1:0] sel,
                                    input logic [TICKET_W-1:0] want,
                                    input logic [DISH_W-1:0] dish,
                                    output reply_type reply);
      int h;
      int t;
      int nt;
      reply = '0;
      if (act == ACT_RESTART) begin
         ticket_counter = TICKET_START;
      end else if ((act == ACT_ENQ || act == ACT_DEQ) && int'(sel) < QUEUES) begin
         h = head_idx[sel];
         t = tail_idx[sel];
         if (act == ACT_ENQ) begin
            nt = (t + 1) % SLOTS;
            if (nt != h) begin
               ticket_slots[sel][t] = '{ticket: ticket_counter, dish: dish};
               tail_idx[sel] = nt;
               reply.accepted = 1'b1;
               reply.ticket = ticket_counter;
               if (ticket_counter == '1) wrap_count++;
               ticket_counter = ticket_counter + 1'b1;
               issued_count++;
            end else begin
               refused_count++;
            end
         end else begin
            if (h != t && ticket_slots[sel][h].ticket == want) begin
               reply.accepted = 1'b1;
               reply.ticket = ticket_slots[sel][h].ticket;
               reply.dish = ticket_slots[sel][h].dish;
               head_idx[sel] = (h + 1) % SLOTS;
               collected_count++;
            end else begin
               refused_count++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      reply_type due;
      reply_type seen;
      if (reset) begin
         for (int q = 0; q < QUEUES; q++) begin
            head_idx[q] = 0;
            tail_idx[q] = 0;
            for (int s = 0; s < SLOTS; s++) ticket_slots[q][s] = '0;
         end
         ticket_counter = TICKET_START;
         owed_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{accepted: rsp_accepted, ticket: rsp_ticket_number, dish: rsp_dish_out};
            if (owed_replies.size() == 0) begin
               report_mismatch("response beat with no reply owed", 1, 0);
            end else begin
               due = owed_replies.pop_front();
               if (seen.accepted !== due.accepted)
                  report_mismatch("accepted", seen.accepted, due.accepted);
               if (seen.ticket !== due.ticket)
                  report_mismatch("ticket_number", seen.ticket, due.ticket);
               if (seen.dish !== due.dish)
                  report_mismatch("dish_out", seen.dish, due.dish);
            end
         end
         if (req_valid && req_ready) begin
            serve_ticket_desk(req_action, req_queue_sel, req_expected_ticket,
                              req_dish_code, due);
            owed_replies.push_back(due);
         end
      end
      for (int q = 0; q < QUEUES; q++) begin
         head_tickets[q] = ticket_slots[q][head_idx[q]].ticket;
         fill_levels[q] = 8'((tail_idx[q] + SLOTS - head_idx[q]) % SLOTS);
      end
      outstanding = owed_replies.size();
      model_tick = ~model_tick;
   end

endmodule

FILE: test/tagged_multi_queue_ticket_fifo_test.sv
module tagged_multi_queue_ticket_fifo_test;
   import tmqtf_pkg::*;

   localparam int QUEUES    = QUEUES_DEF;
   localparam int DEPTH     = DEPTH_DEF;
   localparam int LONG_HOLD = 80;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [ACTION_W-1:0]             req_action;
   logic [SEL_W-1:0]                req_queue_sel;
   logic [TICKET_W-1:0]             req_expected_ticket;
   logic [DISH_W-1:0]               req_dish_code;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_accepted;
   logic [TICKET_W-1:0]             rsp_ticket_number;
   logic [DISH_W-1:0]               rsp_dish_out;

   int                              failures;
   int                              outstanding;
   logic                            model_tick;
   logic [QUEUES-1:0][TICKET_W-1:0] head_tickets;
   logic [QUEUES-1:0][7:0]          fill_levels;
   int                              issued_count;
   int                              collected_count;
   int                              refused_count;
   int                              wrap_count;

   logic                            steady_reader   = 1'b0;
   logic                            hold_off_wanted = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tagged_multi_queue_ticket_fifo #(.QUEUES(QUEUES), .DEPTH(DEPTH)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_queue_sel       (req_queue_sel),
      .req_expected_ticket (req_expected_ticket),
      .req_dish_code       (req_dish_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_ticket_number   (rsp_ticket_number),
      .rsp_dish_out        (rsp_dish_out)
   );

   ticket_fifo_checker #(.QUEUES(QUEUES), .DEPTH(DEPTH)) desk_watch (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_queue_sel       (req_queue_sel),
      .req_expected_ticket (req_expected_ticket),
      .req_dish_code       (req_dish_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_ticket_number   (rsp_ticket_number),
      .rsp_dish_out        (rsp_dish_out),
      .failures            (failures),
      .outstanding         (outstanding),
      .model_tick          (model_tick),
      .head_tickets        (head_tickets),
      .fill_levels         (fill_levels),
      .issued_count        (issued_count),
      .collected_count     (collected_count),
      .refused_count       (refused_count),
      .wrap_count          (wrap_count)
   );

   // holds the beat until it is taken; returns in the step of acceptance
   task automatic offer(input logic [ACTION_W-1:0] act, input logic [SEL_W-1:0] sel,
                        input logic [TICKET_W-1:0] want, input logic [DISH_W-1:0] dish);
      req_valid           <= 1'b1;
      req_action          <= act;
      req_queue_sel       <= sel;
      req_expected_ticket <= want;
      req_dish_code       <= dish;
      @(model_tick);
      while (!(req_valid && req_ready)) @(model_tick);
   endtask

   task automatic random_request(output int counted);
      int pick;
      int q;
      pick = $urandom_range(0, 99);
      q = $urandom_range(0, QUEUES - 1);
      counted = 1;
      if (pick < 44) begin
         if (pick < 38)
            for (int k = 0; k < QUEUES && fill_levels[q] >= DEPTH; k++) q = (q + 1) % QUEUES;
         offer(ACT_ENQ, SEL_W'(q), TICKET_W'($urandom), DISH_W'($urandom));
      end else if (pick < 84) begin
         for (int k = 0; k < QUEUES && fill_levels[q] == 0; k++) q = (q + 1) % QUEUES;
         offer(ACT_DEQ, SEL_W'(q), head_tickets[q], DISH_W'($urandom));
      end else if (pick < 92) begin
         offer(ACT_DEQ, SEL_W'(q), TICKET_W'($urandom), DISH_W'($urandom));
      end else if (pick < 96) begin
         offer(ACT_RESTART, SEL_W'(q), TICKET_W'($urandom), DISH_W'($urandom));
      end else begin
         offer(ACT_UNUSED, SEL_W'(q), TICKET_W'($urandom), DISH_W'($urandom));
         counted = 0;
      end
   endtask

   initial begin : stimulus
      int made;
      int counted;
      int burst;
      int gap;
      logic held;
      logic paused;
      made   = 0;
      held   = 1'b0;
      paused = 1'b0;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_action          <= ACT_ENQ;
      req_queue_sel       <= '0;
      req_expected_ticket <= '0;
      req_dish_code       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(model_tick);

      offer(ACT_ENQ, 2'd0, 16'h0000, 8'h00);
      offer(ACT_ENQ, 2'd1, 16'hFFFF, 8'hFF);
      offer(ACT_ENQ, 2'd1, 16'h0000, 8'hA5);
      offer(ACT_ENQ, 2'd1, 16'h0000, 8'h5A);
      offer(ACT_ENQ, 2'd1, 16'h0000, 8'h3C);            // queue full
      offer(ACT_DEQ, 2'd1, 16'hFFFF, 8'h00);            // wrong ticket
      offer(ACT_DEQ, 2'd1, head_tickets[1], 8'hFF);
      offer(ACT_DEQ, 2'd2, 16'h0000, 8'h00);            // empty queue
      offer(ACT_DEQ, 2'd3, 16'hFFFF, 8'hFF);
      offer(ACT_UNUSED, 2'd2, 16'hFFFF, 8'hFF);
      offer(ACT_RESTART, 2'd3, 16'h0000, 8'h00);
      offer(ACT_ENQ, 2'd3, 16'hFFFF, 8'hFF);            // numbering back at 1
      offer(ACT_ENQ, 2'd2, 16'h0000, 8'h01);
      for (int q = 0; q < QUEUES; q++)
         while (fill_levels[q] != 0) offer(ACT_DEQ, SEL_W'(q), head_tickets[q], 8'h00);

      while (made < 2000) begin
         burst = $urandom_range(1, 30);
         if (!held && made >= 700) begin
            hold_off_wanted = 1'b1;
            held = 1'b1;
            burst = 40;
         end
         repeat (burst) begin
            random_request(counted);
            made += counted;
         end
         if (!paused && made >= 1300) begin
            req_valid <= 1'b0;
            paused = 1'b1;
            while (outstanding != 0) @(model_tick);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(model_tick);
            end
         end
      end

      req_valid <= 1'b0;
      steady_reader = 1'b1;
      while (outstanding != 0) @(model_tick);
      repeat (8) @(model_tick);
      $display("covered %0d tickets issued, %0d collected, %0d requests refused",
               issued_count, collected_count, refused_count);
      $display("counter wrapped %0d time(s); bursts, stalls, a long reader hold-off, a drain",
               wrap_count);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : receiver
      int span;
      rsp_ready <= 1'b0;
      forever begin
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (steady_reader) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            span = $urandom_range(1, 12);
            repeat (span) @(posedge clock);
            if ($urandom_range(0, 3) != 0) begin
               span = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
               rsp_ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule
